@@ rtl/vslsm_pkg.sv @@
// Package: field widths, codes and beat types of the slew-limited 2D smoother.
`default_nettype none
package vslsm_pkg;

   localparam int POS_W    = 32;   // position and speed width, Q.F
   localparam int FRAC_DEF = 16;   // default fraction bits
   localparam int EL_W     = 20;   // elapsed, unsigned Q4.F
   localparam int TF_W     = 28;   // time_factor, unsigned Q12.F
   localparam int LF_W     = 48;   // limit_factor, unsigned Q32.F
   localparam int CSR_IDX_W = 2;

   localparam logic [TF_W-1:0] TF_RESET = TF_W'(262144);
   localparam logic [LF_W-1:0] LF_RESET = LF_W'(262144);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_FACTOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_FACTOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_EN    = 2'd2;

   // function codes
   localparam logic [1:0] FN_UPDATE = 2'd0;
   localparam logic [1:0] FN_LOAD   = 2'd1;
   localparam logic [1:0] FN_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]              func;
      logic [EL_W-1:0]         elapsed;
      logic signed [POS_W-1:0] vec_x;
      logic signed [POS_W-1:0] vec_y;
      logic [POS_W-1:0]        speed_in;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [POS_W-1:0]        speed_out;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/vector2_slew_limited_smoother.sv @@
// Top level: slew-limited first-order 2D position smoother on one shared unit.
`default_nettype none
// Each request beat carries a function code. Update (code 0) moves the stored
// position toward the goal (vec_x, vec_y) by min(elapsed * time_factor, 1) of
// the remaining distance, snaps to the goal when that step rounds to zero
// length, and shortens the step along its direction when it would exceed
// (speed + limit_factor * elapsed) * elapsed. The stored speed then becomes
// the distance moved over elapsed, saturating at all ones. Load (code 1) sets
// position and speed, clear (code 2) zeroes them, code 3 only reports. A tick
// with elapsed * 1000 < 2^FRAC_BITS changes nothing. Every request gives one
// response beat with the state after it. All math runs on one shift-add /
// restoring subtract unit (multiply, divide, square root, one bit per cycle)
// under a small sequencer; req_stall is high while an item is in flight.
// Load, clear and short ticks go straight to the response register; an
// update without smoothing squares the step, takes its root and divides by
// elapsed for the speed. A smoothed update first forms the time fraction and
// the scaled step; a snap then repeats the squares and root on the full
// distance, an uncapped one adds the limit and cap products, and a capped one
// also rescales both components and takes the root again. A finished result
// waits in the response register while the next request is taken. Registers
// are written through csr_we, csr_index and csr_wdata; the user must write
// them only while the block is idle, as the block does not enforce it.
module vector2_slew_limited_smoother
   #(parameter int FRAC_BITS = vslsm_pkg::FRAC_DEF)
   (input  wire                                 clock,
    input  wire                                 reset,
    input  wire                                 req_valid,
    output logic                                req_stall,
    input  wire vslsm_pkg::req_type             req_data,
    output logic                                rsp_valid,
    input  wire                                 rsp_stall,
    output vslsm_pkg::rsp_type                  rsp_data,
    input  wire                                 csr_we,
    input  wire [vslsm_pkg::CSR_IDX_W-1:0]      csr_index,
    input  wire [vslsm_pkg::LF_W-1:0]           csr_wdata);

   import vslsm_pkg::*;

   localparam int W      = POS_W;
   localparam int F      = FRAC_BITS;
   localparam int LEN_W  = W + 1;                    // step and length magnitudes
   localparam int LIMP_W = LF_W + EL_W - F;          // limit width
   localparam int SUM_W  = ((W > LIMP_W) ? W : LIMP_W) + 1;
   localparam int AW0    = SUM_W + EL_W;
   localparam int AW1    = (AW0 > 2 * W + 3) ? AW0 : 2 * W + 3;
   localparam int AW2    = (AW1 > SUM_W + F) ? AW1 : SUM_W + F;
   localparam int AW3    = (AW2 > LF_W + EL_W) ? AW2 : LF_W + EL_W;
   localparam int AW     = (AW3 > W + F + 2) ? AW3 : W + F + 2;
   localparam int CW     = $clog2(W + F + 3);
   localparam logic [EL_W-1:0] MIN_E = EL_W'(((2 ** F) + 999) / 1000);

   typedef enum logic [14:0] {
      S_IDLE = 15'h0001,
      S_FT   = 15'h0002,
      S_AX   = 15'h0004,
      S_AY   = 15'h0008,
      S_SQX  = 15'h0010,
      S_SQY  = 15'h0020,
      S_ROOT = 15'h0040,
      S_LIM  = 15'h0080,
      S_CAP  = 15'h0100,
      S_SCMX = 15'h0200,
      S_SCDX = 15'h0400,
      S_SCMY = 15'h0800,
      S_SCDY = 15'h1000,
      S_SPD  = 15'h2000,
      S_OUT  = 15'h4000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] acc_ff, acc_in, a_ff, a_in, b_ff, b_in, q_ff, q_in;
   logic [W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in, spd_ff, spd_in;
   logic [TF_W-1:0] tf_ff;
   logic [LF_W-1:0] lf_ff;
   logic sm_en_ff;
   logic [EL_W-1:0] e_ff, e_in;
   logic [W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [LEN_W-1:0] dxm_ff, dxm_in, dym_ff, dym_in;
   logic dxn_ff, dxn_in, dyn_ff, dyn_in;
   logic [F:0] ft_ff, ft_in;
   logic [LEN_W-1:0] sxm_ff, sxm_in, sym_ff, sym_in;
   logic [LEN_W-1:0] len_ff, len_in, cap_ff, cap_in;
   logic pass2_ff, pass2_in, goal_ff, goal_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // shared unit
   logic mode_mul, mode_div, mode_sqrt;
   logic [AW+2:0] opl, opr, ures;
   logic ge;
   logic [AW-1:0] acc_step, a_step, b_step, q_step;

   // request side helpers
   logic signed [W:0] dx_new, dy_new;
   logic [LEN_W-1:0] dxm_new, dym_new;
   logic [AW-1:0] acc_sh, ft_full;
   logic [W:0] spd_hi_unused;

   assign mode_mul  = (state_ff == S_FT) || (state_ff == S_AX) || (state_ff == S_AY) ||
                      (state_ff == S_SQX) || (state_ff == S_SQY) || (state_ff == S_LIM) ||
                      (state_ff == S_CAP) || (state_ff == S_SCMX) || (state_ff == S_SCMY);
   assign mode_div  = (state_ff == S_SCDX) || (state_ff == S_SCDY) || (state_ff == S_SPD);
   assign mode_sqrt = (state_ff == S_ROOT);

   always_comb begin
      if (mode_sqrt) begin
         opl = {1'b0, acc_ff, b_ff[AW-1], b_ff[AW-2]};
         opr = {1'b0, q_ff, 2'b01};
      end else if (mode_div) begin
         opl = {2'b00, acc_ff, b_ff[AW-1]};
         opr = {3'b000, a_ff};
      end else begin
         opl = {3'b000, acc_ff};
         opr = {3'b000, a_ff};
      end
      ures = (mode_mul) ? (opl + opr) : (opl + ~opr + (AW+3)'(1));
      ge   = !ures[AW+2];
   end

   always_comb begin
      acc_step = acc_ff;
      a_step   = a_ff;
      b_step   = b_ff;
      q_step   = q_ff;
      if (mode_mul) begin
         if (b_ff[0]) begin
            acc_step = ures[AW-1:0];
         end
         a_step = a_ff << 1;
         b_step = b_ff >> 1;
      end else begin
         acc_step = ge ? ures[AW-1:0] : opl[AW-1:0];
         b_step   = mode_sqrt ? (b_ff << 2) : (b_ff << 1);
         q_step   = {q_ff[AW-2:0], ge};
      end
   end

   assign dx_new  = {req_data.vec_x[W-1], req_data.vec_x} - {cur_x_ff[W-1], cur_x_ff};
   assign dy_new  = {req_data.vec_y[W-1], req_data.vec_y} - {cur_y_ff[W-1], cur_y_ff};
   assign dxm_new = dx_new[W] ? LEN_W'(-dx_new) : LEN_W'(dx_new);
   assign dym_new = dy_new[W] ? LEN_W'(-dy_new) : LEN_W'(dy_new);
   assign acc_sh  = acc_ff >> F;
   assign ft_full = acc_sh;
   assign spd_hi_unused = '0;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      q_in     = q_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      spd_in   = spd_ff;
      e_in     = e_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      dxm_in   = dxm_ff;
      dym_in   = dym_ff;
      dxn_in   = dxn_ff;
      dyn_in   = dyn_ff;
      ft_in    = ft_ff;
      sxm_in   = sxm_ff;
      sym_in   = sym_ff;
      len_in   = len_ff;
      cap_in   = cap_ff;
      pass2_in = pass2_ff;
      goal_in  = goal_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if ((state_ff != S_IDLE) && (state_ff != S_OUT) && (cnt_ff != '0)) begin
         acc_in = acc_step;
         a_in   = a_step;
         b_in   = b_step;
         q_in   = q_step;
         cnt_in = cnt_ff - CW'(1);
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  e_in   = req_data.elapsed;
                  gx_in  = req_data.vec_x;
                  gy_in  = req_data.vec_y;
                  dxm_in = dxm_new;
                  dym_in = dym_new;
                  dxn_in = dx_new[W];
                  dyn_in = dy_new[W];
                  state_in = S_OUT;
                  unique case (req_data.func)
                     FN_UPDATE: begin
                        if (req_data.elapsed >= MIN_E) begin
                           acc_in = '0;
                           cnt_in = CW'(EL_W);
                           if (!sm_en_ff) begin
                              // jump to goal, speed still recomputed
                              goal_in  = 1'b1;
                              pass2_in = 1'b1;
                              sxm_in   = dxm_new;
                              sym_in   = dym_new;
                              a_in     = AW'(dxm_new);
                              b_in     = AW'(dxm_new);
                              cnt_in   = CW'(LEN_W);
                              state_in = S_SQX;
                           end else begin
                              goal_in  = 1'b0;
                              pass2_in = 1'b0;
                              a_in     = AW'(tf_ff);
                              b_in     = AW'(req_data.elapsed);
                              state_in = S_FT;
                           end
                        end
                     end
                     FN_LOAD: begin
                        cur_x_in = req_data.vec_x;
                        cur_y_in = req_data.vec_y;
                        spd_in   = req_data.speed_in;
                     end
                     FN_CLEAR: begin
                        cur_x_in = '0;
                        cur_y_in = '0;
                        spd_in   = '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_FT: begin
               // time fraction, capped at one
               if (ft_full > (AW'(1) << F)) begin
                  ft_in = (F+1)'(1) << F;
               end else begin
                  ft_in = ft_full[F:0];
               end
               acc_in   = '0;
               a_in     = AW'(dxm_ff);
               b_in     = AW'(ft_in);
               cnt_in   = CW'(F + 1);
               state_in = S_AX;
            end
            S_AX: begin
               sxm_in   = acc_sh[LEN_W-1:0];
               acc_in   = '0;
               a_in     = AW'(dym_ff);
               b_in     = AW'(ft_ff);
               cnt_in   = CW'(F + 1);
               state_in = S_AY;
            end
            S_AY: begin
               sym_in   = acc_sh[LEN_W-1:0];
               acc_in   = '0;
               a_in     = AW'(sxm_ff);
               b_in     = AW'(sxm_ff);
               cnt_in   = CW'(LEN_W);
               state_in = S_SQX;
            end
            S_SQX: begin
               // y square accumulates on top of x square
               a_in     = AW'(sym_ff);
               b_in     = AW'(sym_ff);
               cnt_in   = CW'(LEN_W);
               state_in = S_SQY;
            end
            S_SQY: begin
               b_in     = acc_ff << (AW - 2 * LEN_W);
               acc_in   = '0;
               q_in     = '0;
               cnt_in   = CW'(LEN_W);
               state_in = S_ROOT;
            end
            S_ROOT: begin
               if (pass2_ff) begin
                  acc_in   = '0;
                  q_in     = '0;
                  a_in     = AW'(e_ff);
                  b_in     = AW'(q_ff[LEN_W-1:0]) << (AW - LEN_W);
                  cnt_in   = CW'(LEN_W + F);
                  state_in = S_SPD;
               end else begin
                  len_in = q_ff[LEN_W-1:0];
                  if (q_ff[LEN_W-1:0] == '0) begin
                     // zero step: snap to goal
                     goal_in  = 1'b1;
                     pass2_in = 1'b1;
                     sxm_in   = dxm_ff;
                     sym_in   = dym_ff;
                     acc_in   = '0;
                     a_in     = AW'(dxm_ff);
                     b_in     = AW'(dxm_ff);
                     cnt_in   = CW'(LEN_W);
                     state_in = S_SQX;
                  end else begin
                     // speed + limit as floor((speed << F + lf * e) >> F)
                     acc_in   = AW'(spd_ff) << F;
                     a_in     = AW'(lf_ff);
                     b_in     = AW'(e_ff);
                     cnt_in   = CW'(EL_W);
                     state_in = S_LIM;
                  end
               end
            end
            S_LIM: begin
               a_in     = acc_sh;
               b_in     = AW'(e_ff);
               acc_in   = '0;
               cnt_in   = CW'(EL_W);
               state_in = S_CAP;
            end
            S_CAP: begin
               acc_in = '0;
               if (AW'(len_ff) > acc_sh) begin
                  cap_in   = acc_sh[LEN_W-1:0];
                  a_in     = AW'(sxm_ff);
                  b_in     = AW'(acc_sh[LEN_W-1:0]);
                  cnt_in   = CW'(LEN_W);
                  state_in = S_SCMX;
               end else begin
                  // step unchanged, its length is the distance moved
                  q_in     = '0;
                  a_in     = AW'(e_ff);
                  b_in     = AW'(len_ff) << (AW - LEN_W);
                  cnt_in   = CW'(LEN_W + F);
                  state_in = S_SPD;
               end
            end
            S_SCMX, S_SCMY: begin
               acc_in   = acc_ff >> LEN_W;
               b_in     = acc_ff << (AW - LEN_W);
               a_in     = AW'(len_ff);
               q_in     = '0;
               cnt_in   = CW'(LEN_W);
               state_in = (state_ff == S_SCMX) ? S_SCDX : S_SCDY;
            end
            S_SCDX: begin
               sxm_in   = q_ff[LEN_W-1:0];
               acc_in   = '0;
               a_in     = AW'(sym_ff);
               b_in     = AW'(cap_ff);
               cnt_in   = CW'(LEN_W);
               state_in = S_SCMY;
            end
            S_SCDY: begin
               sym_in   = q_ff[LEN_W-1:0];
               pass2_in = 1'b1;
               acc_in   = '0;
               a_in     = AW'(sxm_ff);
               b_in     = AW'(sxm_ff);
               cnt_in   = CW'(LEN_W);
               state_in = S_SQX;
            end
            S_SPD: begin
               if ((q_ff >> W) != AW'(spd_hi_unused)) begin
                  spd_in = '1;
               end else begin
                  spd_in = q_ff[W-1:0];
               end
               if (goal_ff) begin
                  cur_x_in = gx_ff;
                  cur_y_in = gy_ff;
               end else begin
                  cur_x_in = dxn_ff ? (cur_x_ff - sxm_ff[W-1:0]) : (cur_x_ff + sxm_ff[W-1:0]);
                  cur_y_in = dyn_ff ? (cur_y_ff - sym_ff[W-1:0]) : (cur_y_ff + sym_ff[W-1:0]);
               end
               state_in = S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.pos_x     = cur_x_ff;
                  rsp_data_in.pos_y     = cur_y_ff;
                  rsp_data_in.speed_out = spd_ff;
                  state_in              = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         spd_ff       <= '0;
         tf_ff        <= TF_RESET;
         lf_ff        <= LF_RESET;
         sm_en_ff     <= 1'b1;
         pass2_ff     <= 1'b0;
         goal_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         spd_ff       <= spd_in;
         pass2_ff     <= pass2_in;
         goal_ff      <= goal_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TIME_FACTOR:  tf_ff    <= csr_wdata[TF_W-1:0];
               CSR_LIMIT_FACTOR: lf_ff    <= csr_wdata;
               CSR_SMOOTH_EN:    sm_en_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      q_ff        <= q_in;
      e_ff        <= e_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      dxm_ff      <= dxm_in;
      dym_ff      <= dym_in;
      dxn_ff      <= dxn_in;
      dyn_ff      <= dyn_in;
      ft_ff       <= ft_in;
      sxm_ff      <= sxm_in;
      sym_ff      <= sym_in;
      len_ff      <= len_in;
      cap_ff      <= cap_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire
